@@ hdl/svd_pkg.sv @@
`default_nettype none

package svd_pkg;

	localparam int unsigned TokDepth = 4;
	localparam int unsigned ResDepth = 2;
	localparam int unsigned MaxDigits = 7;

	localparam logic [7:0] ChComma = 8'h2c;
	localparam logic [7:0] ChSemi = 8'h3b;
	localparam logic [7:0] ChQuote = 8'h22;
	localparam logic [7:0] ChPlus = 8'h2b;
	localparam logic [7:0] ChSlash = 8'h2f;

	typedef enum logic [2:0] {
		CLS_FINAL,
		CLS_CONT,
		CLS_COMMA,
		CLS_SEMI,
		CLS_QUOTE,
		CLS_OTHER
	} byte_class_t;

	typedef struct packed {
		byte_class_t cls;
		logic [4:0] digit;
	} token_t;

	typedef enum logic [2:0] {
		K_SEG,
		K_END,
		K_BAD_DIGIT,
		K_BAD_LEN,
		K_TOO_MANY,
		K_NO_SRC,
		K_LINE_SEP,
		K_OVERFLOW
	} kind_t;

	typedef enum logic {
		PH_FIRST,
		PH_LATER
	} phase_t;

	typedef struct packed {
		kind_t kind;
		logic signed [31:0] gen_col;
		logic signed [31:0] span_len;
		logic signed [31:0] file_index;
		logic signed [31:0] orig_line;
		logic signed [31:0] orig_col;
		logic is_last;
	} result_t;

endpackage

`default_nettype wire

@@ hdl/svd_queue.sv @@
`default_nettype none

module svd_queue #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 2
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire logic [WIDTH-1:0] wdata,
	output logic full,
	input wire logic pop,
	output logic [WIDTH-1:0] rdata,
	output logic empty
);

	localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CntW = $clog2(DEPTH + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
	localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic do_push;
	logic do_pop;

	assign full = (count_q == FullCnt);
	assign empty = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CntW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CntW'(1);
			end
		end
	end

endmodule

`default_nettype wire

@@ hdl/svd_front.sv @@
`default_nettype none

module svd_front (
	input wire logic [7:0] char_in,
	output svd_pkg::token_t tok
);

	import svd_pkg::*;

	always_comb begin
		tok.cls = CLS_OTHER;
		tok.digit = '0;
		if (char_in inside {[8'h41:8'h5a]}) begin
			tok.cls = CLS_FINAL;
			tok.digit = 5'(char_in - 8'h41);
		end else if (char_in inside {[8'h61:8'h66]}) begin
			tok.cls = CLS_FINAL;
			tok.digit = 5'(char_in - 8'h61 + 8'd26);
		end else if (char_in inside {[8'h67:8'h7a]}) begin
			tok.cls = CLS_CONT;
			tok.digit = 5'(char_in - 8'h67);
		end else if (char_in inside {[8'h30:8'h39]}) begin
			tok.cls = CLS_CONT;
			tok.digit = 5'(char_in - 8'h30 + 8'd20);
		end else if (char_in == ChPlus) begin
			tok.cls = CLS_CONT;
			tok.digit = 5'd30;
		end else if (char_in == ChSlash) begin
			tok.cls = CLS_CONT;
			tok.digit = 5'd31;
		end else if (char_in == ChComma) begin
			tok.cls = CLS_COMMA;
		end else if (char_in == ChSemi) begin
			tok.cls = CLS_SEMI;
		end else if (char_in == ChQuote) begin
			tok.cls = CLS_QUOTE;
		end
	end

endmodule

`default_nettype wire

@@ hdl/svd_back.sv @@
`default_nettype none

module svd_back #(
	parameter int unsigned VALUE_WIDTH = 32
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic fire,
	input wire svd_pkg::token_t tok,
	output logic emit,
	output svd_pkg::result_t res
);

	import svd_pkg::*;

	phase_t phase_q, n_phase;
	logic [VALUE_WIDTH-1:0] accum_q, n_accum;
	logic [2:0] dcount_q, n_dcount;
	logic mid_q, n_mid;
	logic [2:0] nvals_q, n_nvals;
	logic [31:0] seg_q [4];
	logic [31:0] n_seg [4];
	logic prior_q, n_prior;
	logic [31:0] acc_col_q, n_acc_col;
	logic [31:0] acc_file_q, n_acc_file;
	logic [31:0] acc_line_q, n_acc_line;
	logic [31:0] acc_src_q, n_acc_src;

	logic is_digit;
	logic [5:0] shamt;
	logic [VALUE_WIDTH-1:0] shifted;
	logic [VALUE_WIDTH-1:0] acc_new;
	logic [31:0] mag;
	logic [31:0] value;

	assign is_digit = (tok.cls == CLS_FINAL) || (tok.cls == CLS_CONT);
	assign shamt = ({3'b000, dcount_q} << 2) + {3'b000, dcount_q};
	assign shifted = VALUE_WIDTH'(tok.digit) << shamt;
	assign acc_new = accum_q | shifted;
	// VLQ sign bit: bit 0 is the sign, the rest the magnitude.
	assign mag = 32'(acc_new >> 1);
	assign value = acc_new[0] ? (32'd0 - mag) : mag;

	always_comb begin
		logic do_take;
		logic do_close;
		logic do_fail;
		logic do_clear;
		logic due;
		logic full_seg;
		kind_t fkind;

		do_take = 1'b0;
		do_close = 1'b0;
		do_fail = 1'b0;
		do_clear = 1'b0;
		due = 1'b0;
		full_seg = (nvals_q >= 3'd4);
		fkind = K_BAD_DIGIT;
		emit = 1'b0;
		res = '0;

		n_phase = phase_q;
		n_accum = accum_q;
		n_dcount = dcount_q;
		n_mid = mid_q;
		n_nvals = nvals_q;
		n_seg = seg_q;
		n_prior = prior_q;
		n_acc_col = acc_col_q;
		n_acc_file = acc_file_q;
		n_acc_line = acc_line_q;
		n_acc_src = acc_src_q;

		if (mid_q) begin
			do_take = 1'b1;
		end else if (nvals_q == 3'd0) begin
			if (tok.cls == CLS_QUOTE) begin
				do_clear = 1'b1;
				emit = 1'b1;
				res.kind = K_END;
				res.is_last = 1'b1;
			end else if (phase_q == PH_LATER && tok.cls == CLS_COMMA) begin
				// Repeated commas between segments are skipped.
			end else if (phase_q == PH_LATER && tok.cls == CLS_SEMI) begin
				do_fail = 1'b1;
				fkind = K_LINE_SEP;
			end else begin
				do_take = 1'b1;
			end
		end else if (is_digit) begin
			if (nvals_q >= 3'd5) begin
				do_fail = 1'b1;
				fkind = K_TOO_MANY;
			end else begin
				do_take = 1'b1;
			end
		end else begin
			do_close = 1'b1;
		end

		if (do_take) begin
			if (!is_digit) begin
				do_fail = 1'b1;
				fkind = K_BAD_DIGIT;
			end else if (dcount_q == 3'(MaxDigits)) begin
				do_fail = 1'b1;
				fkind = K_OVERFLOW;
			end else if (tok.cls == CLS_CONT) begin
				n_accum = acc_new;
				n_dcount = dcount_q + 3'd1;
				n_mid = 1'b1;
			end else begin
				if (nvals_q < 3'd4) begin
					n_seg[nvals_q[1:0]] = value;
				end
				if (nvals_q < 3'd5) begin
					n_nvals = nvals_q + 3'd1;
				end
				n_accum = '0;
				n_dcount = '0;
				n_mid = 1'b0;
			end
		end

		if (do_close) begin
			if (!(nvals_q inside {3'd1, 3'd4, 3'd5})) begin
				do_fail = 1'b1;
				fkind = K_BAD_LEN;
			end else if (phase_q == PH_FIRST && !full_seg) begin
				do_fail = 1'b1;
				fkind = K_NO_SRC;
			end else begin
				if (phase_q == PH_FIRST) begin
					n_acc_col = seg_q[0];
					n_acc_file = seg_q[1];
					n_acc_line = seg_q[2];
					n_acc_src = seg_q[3];
					n_prior = 1'b1;
					n_phase = PH_LATER;
				end else begin
					// The earlier segment is due if it had a source; its length is this one's column delta.
					due = prior_q;
					res.gen_col = acc_col_q;
					res.span_len = seg_q[0];
					res.file_index = acc_file_q;
					res.orig_line = acc_line_q;
					res.orig_col = acc_src_q;
					n_acc_col = acc_col_q + seg_q[0];
					if (full_seg) begin
						n_acc_file = acc_file_q + seg_q[1];
						n_acc_line = acc_line_q + seg_q[2];
						n_acc_src = acc_src_q + seg_q[3];
					end
					n_prior = full_seg;
				end
				n_nvals = '0;
				for (int i = 0; i < 4; i++) begin
					n_seg[i] = '0;
				end
				case (tok.cls)
					CLS_COMMA: begin
						emit = due;
						res.kind = K_SEG;
						res.is_last = 1'b0;
					end
					CLS_SEMI: begin
						do_fail = 1'b1;
						fkind = K_LINE_SEP;
					end
					CLS_QUOTE: begin
						do_clear = 1'b1;
						emit = 1'b1;
						res.is_last = 1'b1;
						if (due) begin
							res.kind = K_SEG;
						end else begin
							res = '0;
							res.kind = K_END;
							res.is_last = 1'b1;
						end
					end
					default: begin
						do_fail = 1'b1;
						fkind = K_BAD_DIGIT;
					end
				endcase
			end
		end

		if (do_fail) begin
			do_clear = 1'b1;
			emit = 1'b1;
			res = '0;
			res.kind = fkind;
			res.is_last = 1'b1;
		end

		if (do_clear) begin
			n_phase = PH_FIRST;
			n_accum = '0;
			n_dcount = '0;
			n_mid = 1'b0;
			n_nvals = '0;
			for (int i = 0; i < 4; i++) begin
				n_seg[i] = '0;
			end
			n_prior = 1'b0;
			n_acc_col = '0;
			n_acc_file = '0;
			n_acc_line = '0;
			n_acc_src = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_FIRST;
			accum_q <= '0;
			dcount_q <= '0;
			mid_q <= 1'b0;
			nvals_q <= '0;
			for (int i = 0; i < 4; i++) begin
				seg_q[i] <= '0;
			end
			prior_q <= 1'b0;
			acc_col_q <= '0;
			acc_file_q <= '0;
			acc_line_q <= '0;
			acc_src_q <= '0;
		end else if (fire) begin
			phase_q <= n_phase;
			accum_q <= n_accum;
			dcount_q <= n_dcount;
			mid_q <= n_mid;
			nvals_q <= n_nvals;
			seg_q <= n_seg;
			prior_q <= n_prior;
			acc_col_q <= n_acc_col;
			acc_file_q <= n_acc_file;
			acc_line_q <= n_acc_line;
			acc_src_q <= n_acc_src;
		end
	end

endmodule

`default_nettype wire

@@ hdl/source_map_vlq_segment_decoder_top.sv @@
`default_nettype none

// Decodes a source-map mappings string, one byte per word, into segment records.
// Each byte is classified on entry and lands in a four-word token queue; the
// decoder behind it takes one token per cycle while the two-word result queue
// has room, so the block sustains one byte per clock. A result is written into
// the result queue when the decoder takes its byte's token, and shows on the
// result ports once it heads that queue; a receiver that holds off fills the
// result queue, then the token queue, and then raises full. A segment is
// reported only when the next one closes, since its length is that segment's
// column delta; errors and the closing quote give a word with is_last set and
// start a new run. VALUE_WIDTH bounds the bits kept from each VLQ value.

module source_map_vlq_segment_decoder_top #(
	parameter int unsigned VALUE_WIDTH = 32
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	output logic full,
	input wire logic [7:0] char_in,
	output logic empty,
	input wire logic pop,
	output logic [2:0] kind,
	output logic signed [31:0] gen_col,
	output logic signed [31:0] span_len,
	output logic signed [31:0] file_index,
	output logic signed [31:0] orig_line,
	output logic signed [31:0] orig_col,
	output logic is_last
);

	import svd_pkg::*;

	token_t tok_in;
	token_t tok_out;
	logic tok_empty;
	logic res_full;
	logic fire;
	logic emit;
	result_t res_in;
	result_t res_out;

	svd_front u_front (
		.char_in(char_in),
		.tok(tok_in)
	);

	svd_queue #(
		.WIDTH($bits(token_t)),
		.DEPTH(TokDepth)
	) u_tok_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.wdata(tok_in),
		.full(full),
		.pop(fire),
		.rdata(tok_out),
		.empty(tok_empty)
	);

	assign fire = !tok_empty && !res_full;

	svd_back #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.fire(fire),
		.tok(tok_out),
		.emit(emit),
		.res(res_in)
	);

	svd_queue #(
		.WIDTH($bits(result_t)),
		.DEPTH(ResDepth)
	) u_res_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(fire && emit),
		.wdata(res_in),
		.full(res_full),
		.pop(pop),
		.rdata(res_out),
		.empty(empty)
	);

	assign kind = res_out.kind;
	assign gen_col = res_out.gen_col;
	assign span_len = res_out.span_len;
	assign file_index = res_out.file_index;
	assign orig_line = res_out.orig_line;
	assign orig_col = res_out.orig_col;
	assign is_last = res_out.is_last;

endmodule

`default_nettype wire

@@ sim/source_map_vlq_segment_decoder_top_tb.sv @@
`default_nettype none

module source_map_vlq_segment_decoder_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import svd_pkg::*;

	localparam int unsigned ValueWidth = 32;
	localparam logic [63:0] ValueMask = (64'd1 << ValueWidth) - 64'd1;
	localparam int WatchdogLimit = 2000;
	localparam int RandomBytes = 450;
	localparam int PopHoldCycles = 300;
	localparam int DrainCycles = 20;

	typedef struct packed {
		logic [7:0] ch;
		logic fixed;
		kind_t kind;
	} script_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic push;
	logic full;
	logic [7:0] char_in;
	logic empty;
	logic pop;
	logic [2:0] kind;
	logic signed [31:0] gen_col;
	logic signed [31:0] span_len;
	logic signed [31:0] file_index;
	logic signed [31:0] orig_line;
	logic signed [31:0] orig_col;
	logic is_last;

	// Set with char_in on rows whose closing or error word is known without the decoder model.
	logic row_fixed;
	kind_t row_kind;

	result_t pending_words[$];
	logic [7:0] byte_q[$];
	int word_errors = 0;
	int words_popped = 0;
	int idle_cycles = 0;
	bit tx_calm = 1'b0;

	// Decoder state mirrored by the predictor.
	phase_t run_phase;
	logic [31:0] vlq_bits;
	int digits;
	bit in_value;
	int nvals;
	logic [31:0] seg_vals[4];
	bit prev_full;
	logic [31:0] gen_acc;
	logic [31:0] file_acc;
	logic [31:0] line_acc;
	logic [31:0] scol_acc;

	script_row_t script[27] = '{
		'{ChQuote, 1'b1, K_END},
		'{ChComma, 1'b1, K_BAD_DIGIT},
		'{8'h00, 1'b1, K_BAD_DIGIT},
		'{"g", 1'b0, K_SEG},
		'{8'hff, 1'b1, K_BAD_DIGIT},
		'{"B", 1'b0, K_SEG},
		'{ChSemi, 1'b1, K_NO_SRC},
		'{"A", 1'b0, K_SEG},
		'{"A", 1'b0, K_SEG},
		'{ChQuote, 1'b1, K_BAD_LEN},
		'{ChSlash, 1'b0, K_SEG},
		'{ChSlash, 1'b0, K_SEG},
		'{ChSlash, 1'b0, K_SEG},
		'{ChSlash, 1'b0, K_SEG},
		'{ChSlash, 1'b0, K_SEG},
		'{ChSlash, 1'b0, K_SEG},
		'{ChSlash, 1'b0, K_SEG},
		'{"f", 1'b1, K_OVERFLOW},
		'{"A", 1'b0, K_SEG},
		'{"C", 1'b0, K_SEG},
		'{"E", 1'b0, K_SEG},
		'{"G", 1'b0, K_SEG},
		'{ChComma, 1'b0, K_SEG},
		'{"D", 1'b0, K_SEG},
		'{ChComma, 1'b0, K_SEG},
		'{ChComma, 1'b0, K_SEG},
		'{ChSemi, 1'b1, K_LINE_SEP}
	};

	source_map_vlq_segment_decoder_top #(
		.VALUE_WIDTH(ValueWidth)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.char_in(char_in),
		.empty(empty),
		.pop(pop),
		.kind(kind),
		.gen_col(gen_col),
		.span_len(span_len),
		.file_index(file_index),
		.orig_line(orig_line),
		.orig_col(orig_col),
		.is_last(is_last)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic int final_val(input logic [7:0] c);
		if (c >= "A" && c <= "Z") return int'(c - "A");
		if (c >= "a" && c < "g") return int'(c - "a") + 26;
		return -1;
	endfunction

	function automatic int cont_val(input logic [7:0] c);
		if (c >= "g" && c <= "z") return int'(c - "g");
		if (c >= "0" && c <= "9") return int'(c - "0") + 20;
		if (c == ChPlus) return 30;
		if (c == ChSlash) return 31;
		return -1;
	endfunction

	function automatic logic [7:0] fin_char(input logic [4:0] d);
		if (d < 26) return 8'("A") + 8'(d);
		return 8'("a") + 8'(d) - 8'd26;
	endfunction

	function automatic logic [7:0] cont_char(input logic [4:0] d);
		if (d < 20) return 8'("g") + 8'(d);
		if (d < 30) return 8'("0") + 8'(d) - 8'd20;
		if (d == 30) return ChPlus;
		return ChSlash;
	endfunction

	function automatic void append_byte(input logic [7:0] b);
		byte_q = {byte_q, b};
	endfunction

	function automatic void clear_decoder();
		run_phase = PH_FIRST;
		vlq_bits = '0;
		digits = 0;
		in_value = 1'b0;
		nvals = 0;
		seg_vals = '{default: '0};
		prev_full = 1'b0;
		gen_acc = '0;
		file_acc = '0;
		line_acc = '0;
		scol_acc = '0;
	endfunction

	// Any error ends the run: the word carries only the kind and is_last.
	function automatic bit abort_run(input kind_t k, output result_t w);
		clear_decoder();
		w = '0;
		w.kind = k;
		w.is_last = 1'b1;
		return 1'b1;
	endfunction

	function automatic bit take_digit(input logic [7:0] c, output result_t w);
		int fv;
		int cv;
		logic [63:0] acc;
		logic [31:0] mag;
		logic [31:0] v;
		fv = final_val(c);
		cv = cont_val(c);
		w = '0;
		if (fv < 0 && cv < 0) return abort_run(K_BAD_DIGIT, w);
		if (digits >= MaxDigits) return abort_run(K_OVERFLOW, w);
		acc = (64'(vlq_bits) | (64'(fv >= 0 ? fv : cv) << (5 * digits))) & ValueMask;
		if (fv < 0) begin
			vlq_bits = acc[31:0];
			digits++;
			in_value = 1'b1;
			return 1'b0;
		end
		mag = acc[32:1];
		v = acc[0] ? -mag : mag;
		if (nvals < 4) seg_vals[nvals] = v;
		if (nvals < 5) nvals++;
		vlq_bits = '0;
		digits = 0;
		in_value = 1'b0;
		return 1'b0;
	endfunction

	function automatic bit close_segment(input logic [7:0] c, output result_t w);
		bit due;
		result_t seg;
		int n;
		n = nvals;
		due = 1'b0;
		seg = '0;
		w = '0;
		if (n != 1 && n != 4 && n != 5) return abort_run(K_BAD_LEN, w);
		if (run_phase == PH_FIRST) begin
			if (n < 4) return abort_run(K_NO_SRC, w);
			gen_acc = seg_vals[0];
			file_acc = seg_vals[1];
			line_acc = seg_vals[2];
			scol_acc = seg_vals[3];
			prev_full = 1'b1;
			run_phase = PH_LATER;
		end else begin
			// The earlier segment gets its length only now, from this column delta.
			if (prev_full) begin
				due = 1'b1;
				seg.gen_col = gen_acc;
				seg.span_len = seg_vals[0];
				seg.file_index = file_acc;
				seg.orig_line = line_acc;
				seg.orig_col = scol_acc;
			end
			gen_acc += seg_vals[0];
			if (n >= 4) begin
				file_acc += seg_vals[1];
				line_acc += seg_vals[2];
				scol_acc += seg_vals[3];
			end
			prev_full = (n >= 4);
		end
		nvals = 0;
		seg_vals = '{default: '0};
		if (c == ChComma) begin
			w = seg;
			return due;
		end
		if (c == ChSemi) return abort_run(K_LINE_SEP, w);
		if (c == ChQuote) begin
			clear_decoder();
			if (due) begin
				w = seg;
			end else begin
				w.kind = K_END;
			end
			w.is_last = 1'b1;
			return 1'b1;
		end
		return abort_run(K_BAD_DIGIT, w);
	endfunction

	function automatic bit decode_byte(input logic [7:0] c, output result_t w);
		w = '0;
		if (in_value) return take_digit(c, w);
		if (nvals == 0) begin
			if (c == ChQuote) begin
				clear_decoder();
				w.kind = K_END;
				w.is_last = 1'b1;
				return 1'b1;
			end
			if (run_phase == PH_LATER && c == ChComma) return 1'b0;
			if (run_phase == PH_LATER && c == ChSemi) return abort_run(K_LINE_SEP, w);
			return take_digit(c, w);
		end
		if (final_val(c) >= 0 || cont_val(c) >= 0) begin
			if (nvals >= 5) return abort_run(K_TOO_MANY, w);
			return take_digit(c, w);
		end
		return close_segment(c, w);
	endfunction

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic void push_value(input logic [34:0] raw);
		logic [4:0] d;
		do begin
			d = raw[4:0];
			raw = raw >> 5;
			append_byte(raw != 0 ? cont_char(d) : fin_char(d));
		end while (raw != 0);
	endfunction

	// Raw VLQ bits: sign in bit 0. The widest choice can set bits above bit 31, which get dropped.
	function automatic logic [34:0] pick_raw();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 35'($urandom_range(0, 31));
		if (r < 85) return 35'($urandom_range(0, 8191));
		if (r < 95) return 35'($urandom);
		return {5'($urandom_range(0, 31)), 30'($urandom)};
	endfunction

	function automatic int seg_len(input bit first);
		int r;
		r = $urandom_range(0, 99);
		if (r < 40) return 4;
		if (r < 65) return 5;
		if (r < 92) return (first && r < 89) ? 4 : 1;
		if (r < 95) return 2;
		if (r < 97) return 3;
		return 6;
	endfunction

	// One mappings run, mostly well formed, with a broken start, segment or ending now and then.
	function automatic void build_run();
		int nseg;
		int r;
		r = $urandom_range(0, 99);
		if (r < 3) begin
			append_byte(ChQuote);
			return;
		end
		if (r < 7) append_byte(8'($urandom_range(0, 255)));
		nseg = $urandom_range(1, 8);
		for (int s = 0; s < nseg; s++) begin
			if (s > 0) begin
				append_byte(ChComma);
				if ($urandom_range(0, 11) == 0) append_byte(ChComma);
			end
			repeat (seg_len(s == 0)) push_value(pick_raw());
		end
		r = $urandom_range(0, 99);
		if (r < 78) begin
			append_byte(ChQuote);
		end else if (r < 84) begin
			append_byte(ChSemi);
		end else if (r < 89) begin
			append_byte(8'($urandom_range(0, 255)));
		end else if (r < 93) begin
			repeat (8) append_byte(cont_char(5'($urandom_range(0, 31))));
		end else if (r < 96) begin
			append_byte(cont_char(5'($urandom_range(0, 31))));
			append_byte(ChQuote);
		end else begin
			append_byte(ChComma);
			append_byte(ChQuote);
		end
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic fixed, input kind_t fk);
		int gap;
		push <= 1'b1;
		char_in <= b;
		row_fixed <= fixed;
		row_kind <= fk;
		do @(posedge clk); while (full);
		gap = tx_calm ? 0 : idle_len();
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain_words();
		push <= 1'b0;
		@(posedge clk);
		wait (pending_words.size() == 0);
		@(posedge clk);
	endtask

	task automatic log_mismatch(input string what, input result_t want, input result_t got);
		word_errors++;
		if (word_errors <= 10) begin
			$display("%0t: %s", $realtime, what);
			$display("  expected kind %0d col %0d span %0d file %0d line %0d scol %0d last %0b",
				want.kind, want.gen_col, want.span_len, want.file_index,
				want.orig_line, want.orig_col, want.is_last);
			$display("  actual   kind %0d col %0d span %0d file %0d line %0d scol %0d last %0b",
				got.kind, got.gen_col, got.span_len, got.file_index,
				got.orig_line, got.orig_col, got.is_last);
		end
	endtask

	always @(posedge clk) begin
		result_t want;
		result_t got;
		bit hit;
		if (arst_n) begin
			if (push && !full) begin
				hit = decode_byte(char_in, want);
				if (row_fixed) begin
					want = '0;
					want.kind = row_kind;
					want.is_last = 1'b1;
					hit = 1'b1;
				end
				if (hit) pending_words = {pending_words, want};
			end
			if (pop && !empty) begin
				words_popped <= words_popped + 1;
				got.kind = kind_t'(kind);
				got.gen_col = gen_col;
				got.span_len = span_len;
				got.file_index = file_index;
				got.orig_line = orig_line;
				got.orig_col = orig_col;
				got.is_last = is_last;
				if (pending_words.size() == 0) begin
					log_mismatch("word with nothing expected", '0, got);
				end else begin
					want = pending_words.pop_front();
					if (got !== want) log_mismatch("word mismatch", want, got);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WatchdogLimit) begin
				$display("source_map_vlq_segment_decoder_top_tb failed");
				$finish;
			end
		end
	end

	// Receiver: bursts of pop with gaps, one long hold-off so the block backs up.
	initial begin
		int burst;
		int gap;
		bit held;
		held = 1'b0;
		pop <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (!held && words_popped >= 25) begin
				held = 1'b1;
				pop <= 1'b0;
				repeat (PopHoldCycles) @(posedge clk);
			end
			burst = $urandom_range(1, 12);
			pop <= 1'b1;
			repeat (burst) @(posedge clk);
			gap = (words_popped % 20 < 5) ? 0 : idle_len();
			if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	end

	initial begin
		int sent;
		arst_n <= 1'b0;
		push <= 1'b0;
		char_in <= '0;
		row_fixed <= 1'b0;
		row_kind <= K_SEG;
		clear_decoder();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i]) send_byte(script[i].ch, script[i].fixed, script[i].kind);
		drain_words();

		sent = 0;
		while (sent < RandomBytes) begin
			build_run();
			while (byte_q.size() > 0) begin
				tx_calm = (sent >= 380 && sent < 430);
				send_byte(byte_q.pop_front(), 1'b0, K_SEG);
				sent++;
				if (sent == 300) drain_words();
			end
		end

		drain_words();
		repeat (DrainCycles) @(posedge clk);
		// Anything still queued here never came out of the block.
		word_errors += pending_words.size();
		if (word_errors == 0) begin
			$display("source_map_vlq_segment_decoder_top_tb passed");
		end else begin
			$display("source_map_vlq_segment_decoder_top_tb failed");
		end
		$finish;
	end

endmodule

`default_nettype wire
